FILE: hw/rtl/adts_frame_deframer_macros.svh
// Assertion macros used by the ADTS deframer queue.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef ADTS_FRAME_DEFRAMER_MACROS_SVH
`define ADTS_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ADTSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ADTSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/adtsd_pkg.sv
// Package for the ADTS deframer: result kinds, queue entry type and constant tables.
// No dependencies.
`default_nettype none

package adtsd_pkg;

	localparam int HDR_BYTES   = 7;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [11:0] SYNC_WORD    = 12'hFFF;
	localparam logic [2:0]  HDR_LAST_IDX = 3'(HDR_BYTES - 1);
	localparam logic [12:0] HDR_LEN      = 13'(HDR_BYTES);
	localparam logic [3:0]  RATE_ENTRIES = 4'd13;

	typedef enum logic [2:0] {
		KIND_HEADER   = 3'd0,
		KIND_PAYLOAD  = 3'd1,
		KIND_BAD_SYNC = 3'd2,
		KIND_BAD_LEN  = 3'd3,
		KIND_BAD_RATE = 3'd4
	} kind_t;

	// One classified beat, passed from the front end to the result stage.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        frame_end;
		logic        id;
		logic        prot_absent;
		logic [1:0]  profile;
		logic [3:0]  rate_index;
		logic [2:0]  channels;
		logic [12:0] frame_len;
		logic [1:0]  blocks_m1;
	} entry_t;

	function automatic logic [16:0] rate_lookup(input logic [3:0] ridx);
		logic [16:0] r;
		case (ridx)
			4'd0:    r = 17'd96000;
			4'd1:    r = 17'd88200;
			4'd2:    r = 17'd64000;
			4'd3:    r = 17'd48000;
			4'd4:    r = 17'd44100;
			4'd5:    r = 17'd32000;
			4'd6:    r = 17'd24000;
			4'd7:    r = 17'd22050;
			4'd8:    r = 17'd16000;
			4'd9:    r = 17'd12000;
			4'd10:   r = 17'd11025;
			4'd11:   r = 17'd8000;
			4'd12:   r = 17'd7350;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	// Frame duration in microseconds, blocks * 1024 * 1e6 / rate, truncated.
	function automatic logic [19:0] duration_lookup(input logic [3:0] ridx,
			input logic [1:0] blocks_m1);
		logic [19:0] d;
		case ({ridx, blocks_m1})
			{4'd0, 2'd0}:  d = 20'd10666;
			{4'd0, 2'd1}:  d = 20'd21333;
			{4'd0, 2'd2}:  d = 20'd32000;
			{4'd0, 2'd3}:  d = 20'd42666;
			{4'd1, 2'd0}:  d = 20'd11609;
			{4'd1, 2'd1}:  d = 20'd23219;
			{4'd1, 2'd2}:  d = 20'd34829;
			{4'd1, 2'd3}:  d = 20'd46439;
			{4'd2, 2'd0}:  d = 20'd16000;
			{4'd2, 2'd1}:  d = 20'd32000;
			{4'd2, 2'd2}:  d = 20'd48000;
			{4'd2, 2'd3}:  d = 20'd64000;
			{4'd3, 2'd0}:  d = 20'd21333;
			{4'd3, 2'd1}:  d = 20'd42666;
			{4'd3, 2'd2}:  d = 20'd64000;
			{4'd3, 2'd3}:  d = 20'd85333;
			{4'd4, 2'd0}:  d = 20'd23219;
			{4'd4, 2'd1}:  d = 20'd46439;
			{4'd4, 2'd2}:  d = 20'd69659;
			{4'd4, 2'd3}:  d = 20'd92879;
			{4'd5, 2'd0}:  d = 20'd32000;
			{4'd5, 2'd1}:  d = 20'd64000;
			{4'd5, 2'd2}:  d = 20'd96000;
			{4'd5, 2'd3}:  d = 20'd128000;
			{4'd6, 2'd0}:  d = 20'd42666;
			{4'd6, 2'd1}:  d = 20'd85333;
			{4'd6, 2'd2}:  d = 20'd128000;
			{4'd6, 2'd3}:  d = 20'd170666;
			{4'd7, 2'd0}:  d = 20'd46439;
			{4'd7, 2'd1}:  d = 20'd92879;
			{4'd7, 2'd2}:  d = 20'd139319;
			{4'd7, 2'd3}:  d = 20'd185759;
			{4'd8, 2'd0}:  d = 20'd64000;
			{4'd8, 2'd1}:  d = 20'd128000;
			{4'd8, 2'd2}:  d = 20'd192000;
			{4'd8, 2'd3}:  d = 20'd256000;
			{4'd9, 2'd0}:  d = 20'd85333;
			{4'd9, 2'd1}:  d = 20'd170666;
			{4'd9, 2'd2}:  d = 20'd256000;
			{4'd9, 2'd3}:  d = 20'd341333;
			{4'd10, 2'd0}: d = 20'd92879;
			{4'd10, 2'd1}: d = 20'd185759;
			{4'd10, 2'd2}: d = 20'd278639;
			{4'd10, 2'd3}: d = 20'd371519;
			{4'd11, 2'd0}: d = 20'd128000;
			{4'd11, 2'd1}: d = 20'd256000;
			{4'd11, 2'd2}: d = 20'd384000;
			{4'd11, 2'd3}: d = 20'd512000;
			{4'd12, 2'd0}: d = 20'd139319;
			{4'd12, 2'd1}: d = 20'd278639;
			{4'd12, 2'd2}: d = 20'd417959;
			{4'd12, 2'd3}: d = 20'd557278;
			default:       d = 20'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/adts_frame_deframer.sv
// ADTS frame deframer top level: one byte per beat in, at most one result per byte out.
// A result is written to a queue entry and then loaded into the output register after its byte is accepted.
// Throughput: one byte per cycle while the queue has a free entry; output back-pressure can stall it.
// Bytes that complete no result (the first six header bytes) produce nothing.
// Reset (arst_n low, asynchronous) empties the queue and output and restarts header capture.
`default_nettype none

module adts_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [7:0]       payload_byte,
	output logic             frame_end,
	output logic [2:0]       mpeg_version,
	output logic [1:0]       profile,
	output logic [3:0]       rate_index,
	output logic [16:0]      sample_rate,
	output logic [2:0]       channels,
	output logic [12:0]      frame_len,
	output logic [2:0]       block_count,
	output logic [19:0]      duration_us,
	output logic             crc_present
);

	// The front end classifies each beat: header bytes are shifted in until the
	// seventh arrives, when the header is checked; payload bytes are counted down
	// against the frame length. Every beat that makes a result pushes one entry.
	logic              push_valid;
	logic              push_ready;
	adtsd_pkg::entry_t push_entry;

	// The queue lets the front end keep taking bytes while a result waits at the
	// output, so the input side stalls only when both queue entries are held.
	logic              pop_valid;
	logic              pop_ready;
	adtsd_pkg::entry_t pop_entry;

	adtsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	adtsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// The back end looks up the sample rate and frame duration from constant
	// tables, clears header fields on non-header results and registers the lot.
	adtsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_entry    (pop_entry),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.frame_end    (frame_end),
		.mpeg_version (mpeg_version),
		.profile      (profile),
		.rate_index   (rate_index),
		.sample_rate  (sample_rate),
		.channels     (channels),
		.frame_len    (frame_len),
		.block_count  (block_count),
		.duration_us  (duration_us),
		.crc_present  (crc_present)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/adtsd_front.sv
// Front end of the ADTS deframer: gathers header bytes, counts payload, classifies beats.
// Depends on adtsd_pkg.
`default_nettype none

module adtsd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       data_byte,
	output logic                  push_valid,
	input  wire logic             push_ready,
	output adtsd_pkg::entry_t     push_entry
);

	logic [47:0] shift_q;
	logic [2:0]  count_q;
	logic        in_payload_q;
	logic [12:0] bytes_left_q;

	logic [55:0] hdr;
	logic        accept;
	logic        hdr_done;
	logic        hdr_good;
	adtsd_pkg::kind_t hdr_kind;

	assign hdr      = {shift_q, data_byte};
	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign hdr_done = !in_payload_q && (count_q == adtsd_pkg::HDR_LAST_IDX);

	always_comb begin
		if (hdr[55:44] != adtsd_pkg::SYNC_WORD) begin
			hdr_kind = adtsd_pkg::KIND_BAD_SYNC;
		end else if (hdr[25:13] < adtsd_pkg::HDR_LEN) begin
			hdr_kind = adtsd_pkg::KIND_BAD_LEN;
		end else if (hdr[37:34] >= adtsd_pkg::RATE_ENTRIES) begin
			hdr_kind = adtsd_pkg::KIND_BAD_RATE;
		end else begin
			hdr_kind = adtsd_pkg::KIND_HEADER;
		end
		hdr_good = (hdr_kind == adtsd_pkg::KIND_HEADER);
	end

	always_comb begin
		push_valid              = in_valid && (in_payload_q || hdr_done);
		push_entry.data         = data_byte;
		push_entry.id           = hdr[43];
		push_entry.prot_absent  = hdr[40];
		push_entry.profile      = hdr[39:38];
		push_entry.rate_index   = hdr[37:34];
		push_entry.channels     = hdr[32:30];
		push_entry.frame_len    = hdr[25:13];
		push_entry.blocks_m1    = hdr[1:0];
		if (in_payload_q) begin
			push_entry.kind      = adtsd_pkg::KIND_PAYLOAD;
			push_entry.frame_end = (bytes_left_q == 13'd1);
		end else begin
			push_entry.kind      = hdr_kind;
			push_entry.frame_end = hdr_good && (hdr[25:13] == adtsd_pkg::HDR_LEN);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !in_payload_q) begin
			shift_q <= hdr[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			in_payload_q <= 1'b0;
			bytes_left_q <= '0;
		end else if (accept) begin
			if (in_payload_q) begin
				bytes_left_q <= bytes_left_q - 13'd1;
				if (bytes_left_q == 13'd1) begin
					in_payload_q <= 1'b0;
				end
			end else if (hdr_done) begin
				count_q <= '0;
				if (hdr_good && (hdr[25:13] > adtsd_pkg::HDR_LEN)) begin
					in_payload_q <= 1'b1;
					bytes_left_q <= hdr[25:13] - adtsd_pkg::HDR_LEN;
				end
			end else begin
				count_q <= count_q + 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/adtsd_queue.sv
// Short queue of classified beats between the front end and the result stage.
// Depends on adtsd_pkg and the assertion macro header.
`default_nettype none

`include "adts_frame_deframer_macros.svh"

module adtsd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire adtsd_pkg::entry_t push_entry,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output adtsd_pkg::entry_t      pop_entry
);

	adtsd_pkg::entry_t              mem_q [adtsd_pkg::QUEUE_DEPTH];
	logic [adtsd_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [adtsd_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [adtsd_pkg::QCNT_W-1:0]   count_q;
	logic                           push;
	logic                           pop;

	assign push_ready = (count_q != adtsd_pkg::QCNT_W'(adtsd_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == adtsd_pkg::QPTR_W'(adtsd_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == adtsd_pkg::QPTR_W'(adtsd_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ADTSD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= adtsd_pkg::QCNT_W'(adtsd_pkg::QUEUE_DEPTH), "queue count beyond depth")
	`ADTSD_ASSERT_NEXT(a_push_grows, push && !pop, count_q == $past(count_q) + 1'b1, "queue count did not grow on push")
	`ADTSD_ASSERT_NEXT(a_pop_shrinks, pop && !push, count_q == $past(count_q) - 1'b1, "queue count did not shrink on pop")
	`ADTSD_ASSERT_NOW(a_ptr_track, count_q == '0, wr_ptr_q == rd_ptr_q, "empty queue with unequal pointers")

endmodule

`default_nettype wire

FILE: hw/rtl/adtsd_back.sv
// Result stage of the ADTS deframer: decodes header fields and holds the output register.
// Depends on adtsd_pkg.
`default_nettype none

module adtsd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	input  wire adtsd_pkg::entry_t pop_entry,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             kind,
	output logic [7:0]             payload_byte,
	output logic                   frame_end,
	output logic [2:0]             mpeg_version,
	output logic [1:0]             profile,
	output logic [3:0]             rate_index,
	output logic [16:0]            sample_rate,
	output logic [2:0]             channels,
	output logic [12:0]            frame_len,
	output logic [2:0]             block_count,
	output logic [19:0]            duration_us,
	output logic                   crc_present
);

	logic  valid_q;
	logic  load;
	logic  is_hdr;
	logic  is_pay;

	assign pop_ready = !valid_q || out_ready;
	assign load      = pop_valid && pop_ready;
	assign out_valid = valid_q;
	assign is_hdr    = (pop_entry.kind == adtsd_pkg::KIND_HEADER);
	assign is_pay    = (pop_entry.kind == adtsd_pkg::KIND_PAYLOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind         <= pop_entry.kind;
			payload_byte <= is_pay ? pop_entry.data : 8'd0;
			frame_end    <= pop_entry.frame_end;
			mpeg_version <= !is_hdr ? 3'd0 : (pop_entry.id ? 3'd2 : 3'd4);
			profile      <= is_hdr ? pop_entry.profile : 2'd0;
			rate_index   <= is_hdr ? pop_entry.rate_index : 4'd0;
			sample_rate  <= is_hdr ? adtsd_pkg::rate_lookup(pop_entry.rate_index) : 17'd0;
			channels     <= is_hdr ? pop_entry.channels : 3'd0;
			frame_len    <= is_hdr ? pop_entry.frame_len : 13'd0;
			block_count  <= is_hdr ? {1'b0, pop_entry.blocks_m1} + 3'd1 : 3'd0;
			duration_us  <= is_hdr
				? adtsd_pkg::duration_lookup(pop_entry.rate_index, pop_entry.blocks_m1)
				: 20'd0;
			crc_present  <= is_hdr && !pop_entry.prot_absent;
		end
	end

endmodule

`default_nettype wire
